// ===== rtl/hfcrc_pkg.sv =====
package hfcrc_pkg;

	localparam int unsigned FrameBytes = 6;
	localparam logic [7:0] CrcInit = 8'hFF;
	localparam logic [7:0] CrcPoly = 8'h31;
	localparam logic [7:0] CrcTop = 8'h80;

	// Scale factors for the two readings (full scale 65535)
	localparam logic [14:0] TempScale = 15'd17500;
	localparam logic [13:0] HumScale = 14'd10000;
	localparam logic [16:0] FullScale = 17'd65535;
	localparam logic signed [15:0] TempOffset = 16'sd4500;

	// Widths of the scaled products
	localparam int unsigned TempProdW = 31;
	localparam int unsigned HumProdW = 30;

	typedef logic [2:0] pos_t;
	typedef logic [1:0] tally_t;

	// One byte of CRC-8, MSB first, no final xor
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if ((c & CrcTop) != 8'd0) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/humidity_frame_crc_converter.sv =====
// Humidity frame CRC converter. Takes a six-byte sensor read frame one byte
// per request (two words of high byte, low byte, CRC-8 with polynomial 0x31
// and initial value 0xFF), checks both CRCs and, on the byte marked last,
// delivers one result with the raw words, the scaled temperature and
// humidity in hundredths, the CRC error count, a length error flag, a frame
// valid flag and a 16-bit wrapping count of valid frames. Other bytes give
// no result. A byte can be accepted every cycle; a result passes through the
// input register, then the frame update with the scaling multiply into stage
// 2, then the divide-by-65535 correction into the output register. Stages
// with no data accept new work even while the output is held, so one byte
// per cycle is sustained unless results back up.
module humidity_frame_crc_converter
	import hfcrc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          raw_byte,
	input  logic                last_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [14:0]  temperature_centi,
	output logic [13:0]         humidity_centi,
	output logic [15:0]         raw_temperature,
	output logic [15:0]         raw_humidity,
	output logic [1:0]          crc_error_count,
	output logic                length_error,
	output logic                frame_valid,
	output logic [15:0]         valid_count
);

	// Stage 1: input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Frame state
	pos_t        pos_q;
	logic        overrun_q;
	logic [15:0] word_one_q;
	logic [15:0] word_two_q;
	logic [7:0]  crc_q;
	tally_t      tally_q;
	logic [15:0] good_q;

	// Stage 2: products and flags
	logic                   valid_s2;
	logic [TempProdW-1:0]   tprod_s2;
	logic [HumProdW-1:0]    hprod_s2;
	logic [15:0]            w1_s2;
	logic [15:0]            w2_s2;
	tally_t                 tally_s2;
	logic                   len_err_s2;
	logic                   fvalid_s2;
	logic [15:0]            good_s2;

	// Stage 3: output register
	logic        valid_s3;

	logic en_s3, en_s2, en_s1;

	// Advance each stage when the next one has room
	assign en_s3 = !valid_s3 || out_ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = valid_s3;

	// Next frame state from the byte in stage 1
	pos_t        pos_n;
	logic        overrun_n;
	logic [15:0] w1_n;
	logic [15:0] w2_n;
	logic [7:0]  crc_n;
	tally_t      tally_n;
	logic        len_err_n;
	logic        fvalid_n;
	logic [15:0] good_n;
	logic [7:0]  crc_upd;
	logic        take_s1;

	assign crc_upd = crc8_byte(crc_q, byte_s1);
	assign take_s1 = valid_s1 && en_s2;

	always_comb begin
		pos_n = pos_q;
		overrun_n = overrun_q;
		w1_n = word_one_q;
		w2_n = word_two_q;
		crc_n = crc_q;
		tally_n = tally_q;
		unique case (pos_q)
			3'd0, 3'd1: begin
				w1_n = {word_one_q[7:0], byte_s1};
				crc_n = crc_upd;
				pos_n = pos_q + 3'd1;
			end
			3'd3, 3'd4: begin
				w2_n = {word_two_q[7:0], byte_s1};
				crc_n = crc_upd;
				pos_n = pos_q + 3'd1;
			end
			3'd2, 3'd5: begin
				if (byte_s1 != crc_q && tally_q != 2'd3) begin
					tally_n = tally_q + 2'd1;
				end
				crc_n = CrcInit;
				pos_n = pos_q + 3'd1;
			end
			default: begin
				overrun_n = 1'b1;
			end
		endcase
		len_err_n = overrun_n || (pos_n != pos_t'(FrameBytes));
		fvalid_n = !len_err_n && (tally_n == 2'd0);
		good_n = fvalid_n ? good_q + 16'd1 : good_q;
	end

	// Input register and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q <= '0;
			overrun_q <= 1'b0;
			word_one_q <= '0;
			word_two_q <= '0;
			crc_q <= CrcInit;
			tally_q <= '0;
			good_q <= '0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (take_s1) begin
				if (last_s1) begin
					// Close the frame and start a new one
					pos_q <= '0;
					overrun_q <= 1'b0;
					word_one_q <= '0;
					word_two_q <= '0;
					crc_q <= CrcInit;
					tally_q <= '0;
					good_q <= good_n;
				end else begin
					pos_q <= pos_n;
					overrun_q <= overrun_n;
					word_one_q <= w1_n;
					word_two_q <= w2_n;
					crc_q <= crc_n;
					tally_q <= tally_n;
				end
			end
		end
	end

	// Hold the request payload in stage 1
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			byte_s1 <= raw_byte;
			last_s1 <= last_byte;
		end
	end

	// Stage 2: only the last byte of a frame makes a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && last_s1) begin
			tprod_s2 <= TempProdW'(w1_n) * TempProdW'(TempScale);
			hprod_s2 <= HumProdW'(w2_n) * HumProdW'(HumScale);
			w1_s2 <= w1_n;
			w2_s2 <= w2_n;
			tally_s2 <= tally_n;
			len_err_s2 <= len_err_n;
			fvalid_s2 <= fvalid_n;
			good_s2 <= good_n;
		end
	end

	// Divide by 65535: quotient of x>>16, then one correction step
	logic [14:0]        tq0;
	logic [16:0]        trem;
	logic [14:0]        tquot;
	logic [13:0]        hq0;
	logic [16:0]        hrem;
	logic [13:0]        hquot;
	logic signed [15:0] temp_full;

	always_comb begin
		tq0 = tprod_s2[TempProdW-1:16];
		trem = {1'b0, tprod_s2[15:0]} + {2'b00, tq0};
		tquot = (trem >= FullScale) ? tq0 + 15'd1 : tq0;
		hq0 = hprod_s2[HumProdW-1:16];
		hrem = {1'b0, hprod_s2[15:0]} + {3'b000, hq0};
		hquot = (hrem >= FullScale) ? hq0 + 14'd1 : hq0;
		temp_full = signed'({1'b0, tquot}) - TempOffset;
	end

	// Stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			temperature_centi <= temp_full[14:0];
			humidity_centi <= hquot;
			raw_temperature <= w1_s2;
			raw_humidity <= w2_s2;
			crc_error_count <= tally_s2;
			length_error <= len_err_s2;
			frame_valid <= fvalid_s2;
			valid_count <= good_s2;
		end
	end

endmodule

// ===== verif/humidity_frame_crc_converter_tb.sv =====
module humidity_frame_crc_converter_tb;
	import hfcrc_pkg::*;

	typedef struct packed {
		logic [14:0] temp_centi;
		logic [13:0] hum_centi;
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
		logic [1:0]  crc_errors;
		logic        len_error;
		logic        good;
		logic [15:0] good_total;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] raw_byte = 8'h00;
	logic last_byte = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic signed [14:0] temperature_centi;
	logic [13:0] humidity_centi;
	logic [15:0] raw_temperature;
	logic [15:0] raw_humidity;
	logic [1:0] crc_error_count;
	logic length_error;
	logic frame_valid;
	logic [15:0] valid_count;

	// Frame decoder model state
	logic [2:0]  frame_pos;
	logic        frame_overrun;
	logic [15:0] temp_word;
	logic [15:0] hum_word;
	logic [7:0]  word_crc;
	logic [1:0]  crc_misses;
	logic [15:0] good_frame_total;

	reading_t    pending_readings[$];
	reading_t    head_reading;
	int unsigned mismatches = 0;
	int unsigned readings_checked = 0;
	int unsigned frames_sent = 0;
	int unsigned bytes_sent = 0;
	int unsigned next_gap = 1;
	int unsigned ready_hold = 0;
	int unsigned settle_cycles = 0;
	bit          sender_steady = 1'b0;
	bit          receiver_steady = 1'b0;

	humidity_frame_crc_converter uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.raw_byte          (raw_byte),
		.last_byte         (last_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.raw_temperature   (raw_temperature),
		.raw_humidity      (raw_humidity),
		.crc_error_count   (crc_error_count),
		.length_error      (length_error),
		.frame_valid       (frame_valid),
		.valid_count       (valid_count)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// CRC-8 over one byte, bit serial, MSB first
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] acc;
		logic fb;
		acc = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = acc[7] ^ d[i];
			acc = {acc[6:0], 1'b0};
			if (fb) begin
				acc = acc ^ CrcPoly;
			end
		end
		return acc;
	endfunction

	function automatic void clear_frame_state();
		frame_pos = 3'd0;
		frame_overrun = 1'b0;
		temp_word = 16'h0000;
		hum_word = 16'h0000;
		word_crc = CrcInit;
		crc_misses = 2'd0;
	endfunction

	// Advance the frame model by one byte; return 1 when it closes a frame
	function automatic bit absorb_byte(input logic [7:0] b, input logic is_last,
			output reading_t r);
		int unsigned t_scaled;
		int unsigned h_scaled;
		int temp_signed;
		logic len_bad;
		logic ok;
		r = '0;
		if (frame_pos >= FrameBytes) begin
			frame_overrun = 1'b1;
		end else begin
			if (frame_pos % 3 == 2) begin
				if (b != word_crc && crc_misses != 2'd3) begin
					crc_misses = crc_misses + 2'd1;
				end
				word_crc = CrcInit;
			end else begin
				word_crc = crc_step(word_crc, b);
				if (frame_pos >= 3) begin
					hum_word = {hum_word[7:0], b};
				end else begin
					temp_word = {temp_word[7:0], b};
				end
			end
			frame_pos = frame_pos + 3'd1;
		end
		if (!is_last) begin
			return 1'b0;
		end
		len_bad = frame_overrun || frame_pos != FrameBytes;
		ok = !len_bad && crc_misses == 2'd0;
		if (ok) begin
			good_frame_total = good_frame_total + 16'd1;
		end
		t_scaled = 32'(temp_word) * 17500 / 65535;
		h_scaled = 32'(hum_word) * 10000 / 65535;
		temp_signed = int'(t_scaled) - 4500;
		r.temp_centi = temp_signed[14:0];
		r.hum_centi = h_scaled[13:0];
		r.temp_raw = temp_word;
		r.hum_raw = hum_word;
		r.crc_errors = crc_misses;
		r.len_error = len_bad;
		r.good = ok;
		r.good_total = good_frame_total;
		clear_frame_state();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 50) begin
			$display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	// Take results, stall at random, check against the oldest expected reading
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_readings.size() == 0) begin
					report_mismatch("result with no frame closed", 32'(valid_count), 0);
				end else begin
					head_reading = pending_readings.pop_front();
					compare_field("temperature_centi", {17'd0, temperature_centi},
						{17'd0, head_reading.temp_centi});
					compare_field("humidity_centi", {18'd0, humidity_centi},
						{18'd0, head_reading.hum_centi});
					compare_field("raw_temperature", {16'd0, raw_temperature},
						{16'd0, head_reading.temp_raw});
					compare_field("raw_humidity", {16'd0, raw_humidity},
						{16'd0, head_reading.hum_raw});
					compare_field("crc_error_count", {30'd0, crc_error_count},
						{30'd0, head_reading.crc_errors});
					compare_field("length_error", {31'd0, length_error},
						{31'd0, head_reading.len_error});
					compare_field("frame_valid", {31'd0, frame_valid},
						{31'd0, head_reading.good});
					compare_field("valid_count", {16'd0, valid_count},
						{16'd0, head_reading.good_total});
					readings_checked++;
				end
				ready_hold = receiver_steady ? 0 : $urandom_range(0, 7);
			end else if (ready_hold == 0 && !receiver_steady && $urandom_range(0, 15) == 0) begin
				ready_hold = $urandom_range(1, 7);
			end
			if (ready_hold != 0) begin
				out_ready <= 1'b0;
				ready_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Issue one byte request and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		reading_t r;
		if (next_gap != 0) begin
			repeat (next_gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (absorb_byte(b, is_last, r)) begin
			pending_readings.push_back(r);
		end
		next_gap = sender_steady ? 0 : $urandom_range(0, 7);
		if (next_gap != 0) begin
			in_valid <= 1'b0;
		end
	endtask

	// Drop valid if it is still held for a back-to-back request
	task automatic pause_sender();
		if (next_gap == 0) begin
			in_valid <= 1'b0;
			next_gap = 1;
		end
	endtask

	task automatic wait_for_readings();
		pause_sender();
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Send a frame of n_bytes; corrupt flags damage the CRC of each word
	task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
			input logic [1:0] corrupt, input int unsigned n_bytes);
		logic [7:0] seq [0:8];
		seq[0] = t_word[15:8];
		seq[1] = t_word[7:0];
		seq[2] = crc_step(crc_step(CrcInit, t_word[15:8]), t_word[7:0]);
		seq[3] = h_word[15:8];
		seq[4] = h_word[7:0];
		seq[5] = crc_step(crc_step(CrcInit, h_word[15:8]), h_word[7:0]);
		if (corrupt[0]) begin
			seq[2] = seq[2] ^ 8'($urandom_range(1, 255));
		end
		if (corrupt[1]) begin
			seq[5] = seq[5] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 6; i < 9; i++) begin
			seq[i] = 8'($urandom);
		end
		for (int i = 0; i < n_bytes; i++) begin
			send_byte(seq[i], i == n_bytes - 1);
		end
		frames_sent++;
	endtask

	// Extreme words, both CRCs bad, short, single-byte and long frames
	task automatic test_directed();
		send_frame(16'h0000, 16'hFFFF, 2'b00, 6);
		send_frame(16'hFFFF, 16'h0000, 2'b11, 6);
		send_frame(16'h8000, 16'h7FFF, 2'b00, 4);
		send_frame(16'h1234, 16'h5678, 2'b00, 1);
		send_frame(16'hA5A5, 16'h5A5A, 2'b00, 7);
	endtask

	// Mostly well-formed frames, some with bad CRCs or wrong length
	task automatic test_random_frames(input int unsigned n_frames);
		int unsigned pick;
		for (int f = 0; f < n_frames; f++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(pick_word(), pick_word(), 2'b00, 6);
			end else if (pick < 82) begin
				send_frame(pick_word(), pick_word(), 2'($urandom_range(1, 3)), 6);
			end else if (pick < 91) begin
				send_frame(pick_word(), pick_word(), 2'($urandom), $urandom_range(1, 5));
			end else begin
				send_frame(pick_word(), pick_word(), 2'($urandom), $urandom_range(7, 9));
			end
			if (f % 40 == 39) begin
				wait_for_readings();
			end
		end
	endtask

	// Random bytes with random frame ends; close the last frame at the end
	task automatic test_byte_noise(input int unsigned n_bytes);
		for (int i = 0; i < n_bytes; i++) begin
			send_byte(8'($urandom), $urandom_range(0, 7) == 0);
		end
		send_byte(8'($urandom), 1'b1);
	endtask

	// Back-to-back good frames with the receiver always ready
	task automatic test_steady_stream(input int unsigned n_frames);
		sender_steady = 1'b1;
		receiver_steady = 1'b1;
		for (int f = 0; f < n_frames; f++) begin
			send_frame(pick_word(), pick_word(), 2'b00, 6);
		end
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
	endtask

	initial begin
		clear_frame_state();
		good_frame_total = 16'h0000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames(160);
		test_byte_noise(200);
		test_steady_stream(15);
		test_random_frames(20);

		// Let the pipeline drain, bounded
		pause_sender();
		while (pending_readings.size() != 0 && settle_cycles < 2000) begin
			@(posedge clk);
			settle_cycles++;
		end
		repeat (8) @(posedge clk);
		if (pending_readings.size() != 0) begin
			report_mismatch("readings never delivered", pending_readings.size(), 0);
		end

		$display("Sent %0d bytes in %0d frames plus noise, checked %0d readings.",
			bytes_sent, frames_sent, readings_checked);
		$display("Frames counted valid: %0d, mismatches: %0d.", good_frame_total, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== humidity_frame_crc_converter.f =====
rtl/hfcrc_pkg.sv
rtl/humidity_frame_crc_converter.sv
verif/humidity_frame_crc_converter_tb.sv
